### design/pfd_pkg.sv
// Shared types and constants for the pattern fragment dedup block.
package pfd_pkg;

   localparam int unsigned SYM_W = 7;

   // Controller to datapath commands
   typedef struct packed {
      logic store_sym;   // write accepted symbol
      logic div_start;   // begin m / f
      logic div_step;    // one restoring divide step
      logic frag_init;   // i = 0, set up fragment i
      logic frag_next;   // i++, set up fragment
      logic cand_init;   // j = 0, k = 0
      logic cand_next;   // j++, k = 0
      logic cmp_eval;    // compare read data, k++
      logic set_dup;     // record j as duplicate
      logic emit;        // load output register
      logic clear_load;  // load count back to zero
   } pfd_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic div_done;
      logic last_frag;   // i + 1 == f
      logic cand_done;   // j == i
      logic len_differ;  // length of j differs from i
      logic cmp_end;     // k == length
      logic sym_differ;  // read data mismatch
      logic out_busy;    // output register full and not taken
   } pfd_stat_type;

endpackage

### design/pfd_ram.sv
// Generic single write, single registered read RAM.
module pfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### design/pfd_datapath.sv
// Datapath: pattern stores, divider, fragment geometry, compare and output register.
module pfd_datapath #(
   parameter int MAX_PATTERN   = 256,
   parameter int MAX_FRAGMENTS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  pfd_pkg::pfd_cmd_type       cmd,
   output pfd_pkg::pfd_stat_type      stat,
   input  logic [6:0]                 req_symbol,
   input  logic [5:0]                 cfg_frags,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic [4:0]                 rsp_frag_index,
   output logic [7:0]                 rsp_frag_start,
   output logic [8:0]                 rsp_frag_length,
   output logic signed [5:0]          rsp_dup_of,
   output logic [5:0]                 rsp_unique_count,
   output logic                       rsp_last_fragment
);
   localparam int AW  = $clog2(MAX_PATTERN);
   localparam int LW  = $clog2(MAX_PATTERN + 1);
   localparam int FW  = $clog2(MAX_FRAGMENTS + 1);
   localparam int PW  = LW + FW;
   localparam int SYMW = pfd_pkg::SYM_W;

   logic [LW-1:0] load_ff, load_in;
   logic [FW-1:0] f_ff, f_in, f_sat;
   logic [LW-1:0] q_ff, q_in, rem_ff, rem_in;
   logic [LW-1:0] dcnt_ff, dcnt_in;
   logic [FW-1:0] i_ff, i_in, j_ff, j_in;
   logic [LW-1:0] k_ff, k_in;
   logic [PW-1:0] bi_ff, bi_in, bj_ff, bj_in;
   logic [LW-1:0] li_ff, li_in, lj_ff, lj_in;
   logic [FW-1:0] dup_ff, dup_in;
   logic          dupv_ff, dupv_in;
   logic [FW-1:0] uniq_ff, uniq_in;
   logic          ov_ff, ov_in;
   logic [4:0]    oi_ff; logic [7:0] os_ff; logic [8:0] ol_ff;
   logic [5:0]    od_ff, ou_ff; logic olast_ff;
   logic [LW:0]   trial;
   logic [SYMW-1:0] rda, rdb;
   logic [PW-1:0] pa, pb;

   // Fragment geometry for index x
   function automatic logic [PW-1:0] fbegin(input logic [FW-1:0] x,
                                           input logic [LW-1:0] q,
                                           input logic [LW-1:0] r);
      logic [PW-1:0] xq;
      xq = PW'(x) * PW'(q);
      if (LW'(x) < r) fbegin = xq + PW'(x);
      else            fbegin = xq + PW'(r);
   endfunction

   function automatic logic [LW-1:0] flen(input logic [FW-1:0] x,
                                         input logic [LW-1:0] q,
                                         input logic [LW-1:0] r);
      flen = (LW'(x) < r) ? q + LW'(1) : q;
   endfunction

   always_comb begin
      f_sat = FW'(cfg_frags);
      if (cfg_frags == 6'd0) f_sat = FW'(1);
      else if (7'(cfg_frags) > 7'(MAX_FRAGMENTS)) f_sat = FW'(MAX_FRAGMENTS);
   end

   assign trial = {rem_ff, q_ff[LW-1]} - (LW+1)'(f_ff);
   assign pa = bi_ff + PW'(k_ff);
   assign pb = bj_ff + PW'(k_ff);

   always_comb begin
      load_in = load_ff; f_in = f_ff; q_in = q_ff; rem_in = rem_ff; dcnt_in = dcnt_ff;
      i_in = i_ff; j_in = j_ff; k_in = k_ff; bi_in = bi_ff; bj_in = bj_ff;
      li_in = li_ff; lj_in = lj_ff; dup_in = dup_ff; dupv_in = dupv_ff;
      uniq_in = uniq_ff; ov_in = ov_ff;
      if (cmd.store_sym && load_ff < LW'(MAX_PATTERN)) load_in = load_ff + LW'(1);
      if (cmd.clear_load) load_in = '0;
      if (cmd.div_start) begin
         f_in = f_sat; rem_in = '0; dcnt_in = '0;
         q_in = (cmd.store_sym && load_ff < LW'(MAX_PATTERN)) ? load_ff + LW'(1) : load_ff;
      end
      if (cmd.div_step) begin
         dcnt_in = dcnt_ff + LW'(1);
         if (!trial[LW]) begin
            rem_in = trial[LW-1:0]; q_in = {q_ff[LW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[LW-2:0], q_ff[LW-1]}; q_in = {q_ff[LW-2:0], 1'b0};
         end
      end
      if (cmd.frag_init || cmd.frag_next) begin
         i_in  = cmd.frag_init ? '0 : i_ff + FW'(1);
         bi_in = fbegin(i_in, q_ff, rem_ff);
         li_in = flen(i_in, q_ff, rem_ff);
         dupv_in = 1'b0;
         if (cmd.frag_init) uniq_in = '0;
      end
      if (cmd.cand_init || cmd.cand_next) begin
         j_in  = cmd.cand_init ? '0 : j_ff + FW'(1);
         bj_in = fbegin(j_in, q_ff, rem_ff);
         lj_in = flen(j_in, q_ff, rem_ff);
         k_in  = '0;
      end
      if (cmd.cmp_eval) k_in = k_ff + LW'(1);
      if (cmd.set_dup) begin
         dup_in = j_ff; dupv_in = 1'b1;
      end
      if (cmd.emit) begin
         ov_in = 1'b1;
         if (!dupv_ff) uniq_in = uniq_ff + FW'(1);
      end else if (rsp_ready) begin
         ov_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= '0; ov_ff <= 1'b0; uniq_ff <= '0;
      end else begin
         load_ff <= load_in; ov_ff <= ov_in; uniq_ff <= uniq_in;
      end
      f_ff <= f_in; q_ff <= q_in; rem_ff <= rem_in; dcnt_ff <= dcnt_in;
      i_ff <= i_in; j_ff <= j_in; k_ff <= k_in; bi_ff <= bi_in; bj_ff <= bj_in;
      li_ff <= li_in; lj_ff <= lj_in; dup_ff <= dup_in; dupv_ff <= dupv_in;
      if (cmd.emit) begin
         oi_ff <= 5'(i_ff); os_ff <= 8'(bi_ff); ol_ff <= 9'(li_ff);
         od_ff <= dupv_ff ? 6'(dup_ff) : 6'h3F;
         ou_ff <= dupv_ff ? 6'(uniq_ff) : 6'(uniq_ff + FW'(1));
         olast_ff <= (i_ff + FW'(1) == f_ff);
      end
   end

   // Two copies of the pattern so two positions are read in one cycle
   pfd_ram #(.WIDTH(SYMW), .DEPTH(MAX_PATTERN)) u_ram_a (
      .clock, .wr_en(cmd.store_sym && load_ff < LW'(MAX_PATTERN)),
      .wr_addr(load_ff[AW-1:0]), .wr_data(req_symbol),
      .rd_addr(pa[AW-1:0]), .rd_data(rda));
   pfd_ram #(.WIDTH(SYMW), .DEPTH(MAX_PATTERN)) u_ram_b (
      .clock, .wr_en(cmd.store_sym && load_ff < LW'(MAX_PATTERN)),
      .wr_addr(load_ff[AW-1:0]), .wr_data(req_symbol),
      .rd_addr(pb[AW-1:0]), .rd_data(rdb));

   assign stat.div_done   = (dcnt_ff == LW'(LW));
   assign stat.last_frag  = (i_ff + FW'(1) == f_ff);
   assign stat.cand_done  = (j_ff == i_ff);
   assign stat.len_differ = (lj_ff != li_ff);
   assign stat.cmp_end    = (k_ff == li_ff);
   assign stat.sym_differ = (rda != rdb);
   assign stat.out_busy   = ov_ff && !rsp_ready;

   assign rsp_valid = ov_ff;
   assign rsp_frag_index = oi_ff;
   assign rsp_frag_start = os_ff;
   assign rsp_frag_length = ol_ff;
   assign rsp_dup_of = od_ff;
   assign rsp_unique_count = ou_ff;
   assign rsp_last_fragment = olast_ff;
endmodule

### design/pfd_ctrl.sv
// Controller state machine sequencing load, divide, compare and emit.
module pfd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_last_symbol,
   output logic                  req_ready,
   output pfd_pkg::pfd_cmd_type  cmd,
   input  pfd_pkg::pfd_stat_type stat
);
   typedef enum logic [7:0] {
      S_LOAD  = 8'b0000_0001,
      S_DIV   = 8'b0000_0010,
      S_FRAG  = 8'b0000_0100,
      S_CAND  = 8'b0000_1000,
      S_ISSUE = 8'b0001_0000,
      S_EVAL  = 8'b0010_0000,
      S_EMIT  = 8'b0100_0000,
      S_WAIT  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.store_sym = 1'b1;
               if (req_last_symbol) begin
                  cmd.div_start = 1'b1;
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (stat.div_done) begin
               cmd.frag_init = 1'b1;
               state_in = S_FRAG;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_FRAG: begin
            cmd.cand_init = 1'b1;
            state_in = S_CAND;
         end
         S_CAND: begin
            if (stat.cand_done) state_in = S_EMIT;
            else if (stat.len_differ) cmd.cand_next = 1'b1;
            else state_in = S_ISSUE;
         end
         S_ISSUE: begin
            if (stat.cmp_end) begin
               cmd.set_dup = 1'b1;
               state_in = S_EMIT;
            end else begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (stat.sym_differ) begin
               cmd.cand_next = 1'b1;
               state_in = S_CAND;
            end else begin
               cmd.cmp_eval = 1'b1;
               state_in = S_ISSUE;
            end
         end
         S_EMIT: begin
            if (!stat.out_busy) begin
               cmd.emit = 1'b1;
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (stat.last_frag) begin
               cmd.clear_load = 1'b1;
               state_in = S_LOAD;
            end else begin
               cmd.frag_next = 1'b1;
               state_in = S_FRAG;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_LOAD;
      else       state_ff <= state_in;
   end
endmodule

### design/pattern_fragment_dedup.sv
// Top level of the pattern fragment dedup block.
// Symbols load one transaction per cycle into an on-chip pattern store (up to
// MAX_PATTERN; extra symbols are dropped but a last mark still closes the
// pattern). After the last symbol the block stops accepting, divides the
// length by the fragment count with a restoring divider ($clog2(MAX_PATTERN+1)
// steps), then for each fragment compares it against each earlier fragment of
// equal length one symbol position at a time, through two read ports of
// duplicated stores. Each fragment is set up, tried against the earlier
// fragments of equal length and emitted; a fragment stops at its first
// duplicate. A result held by the sink stalls the next fragment. Results
// leave through a registered output stage; the fragment count register is
// taken when the last symbol lands.
module pattern_fragment_dedup #(
   parameter int MAX_PATTERN   = 256,
   parameter int MAX_FRAGMENTS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [6:0]        req_symbol,
   input  logic              req_last_symbol,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [4:0]        rsp_frag_index,
   output logic [7:0]        rsp_frag_start,
   output logic [8:0]        rsp_frag_length,
   output logic signed [5:0] rsp_dup_of,
   output logic [5:0]        rsp_unique_count,
   output logic              rsp_last_fragment,
   input  logic              csr_we,
   input  logic [5:0]        csr_wdata
);
   pfd_pkg::pfd_cmd_type  cmd;
   pfd_pkg::pfd_stat_type stat;
   logic [5:0] frags_ff;

   // Fragment count register, reset to one
   always_ff @(posedge clock) begin
      if (reset)       frags_ff <= 6'd1;
      else if (csr_we) frags_ff <= csr_wdata;
   end

   pfd_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_last_symbol, .req_ready, .cmd, .stat);

   pfd_datapath #(.MAX_PATTERN(MAX_PATTERN), .MAX_FRAGMENTS(MAX_FRAGMENTS)) u_dp (
      .clock, .reset, .cmd, .stat, .req_symbol, .cfg_frags(frags_ff),
      .rsp_ready, .rsp_valid, .rsp_frag_index, .rsp_frag_start, .rsp_frag_length,
      .rsp_dup_of, .rsp_unique_count, .rsp_last_fragment);
endmodule

### design/pfd_checker.sv
// Port level checker for the pattern fragment dedup block, with its bind.
module pfd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic signed [5:0] rsp_dup_of,
   input logic [5:0]        rsp_unique_count,
   input logic              rsp_last_fragment
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp dropped");
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
      $stable({rsp_dup_of, rsp_unique_count, rsp_last_fragment}))
      else $error("rsp payload changed while waiting");
   a_uniq_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_unique_count != 6'd0) else $error("zero unique count");
   a_first_is_unique: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_unique_count == 6'd1 && rsp_dup_of != -6'sd1 |->
      !rsp_last_fragment || rsp_dup_of == 6'sd0) else $error("bad dup on first");
endmodule

bind pattern_fragment_dedup pfd_checker u_pfd_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_dup_of, .rsp_unique_count, .rsp_last_fragment);
